### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the session slot allocator.
// Depends on nothing; users provide clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked outside reset only.
`define SSA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ssa assertion failed");
// Checked at every edge, reset included.
`define SSA_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) else $error("ssa assertion failed");
`else
`define SSA_ASSERT(lbl, prop)
`define SSA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

### rtl/ssa_pkg.sv
// Shared types and codes of the session slot allocator.
// No dependencies.
package ssa_pkg;

	localparam int WORD_W = 32;
	localparam int BIT_W = 5;

	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_NO_SLOT = 2'd1;
	localparam logic [1:0] STATUS_NOT_BUSY = 2'd2;

	localparam logic [31:0] SEQ_INIT = 32'd1;

	typedef struct packed {
		logic       action;
		logic [5:0] slot_index;
		logic [5:0] srv_high;
		logic [5:0] tgt_high;
		logic       was_sent;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  granted_slot;
		logic [31:0] sequence_number;
		logic [5:0]  highest_in_use;
	} rsp_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_READ,
		S_EXEC,
		S_WAIT,
		S_DONE
	} state_t;

endpackage

### rtl/session_slot_allocator_top.sv
// Session slot allocator: free map and sequence numbers in RAM, control FSM.
// Depends on ssa_pkg, ssa_prienc and assert_macros.svh.
//
// Usage: a request (req, req_valid/req_ready) either allocates the lowest
// free slot at or below the target limit, or frees a slot. Every request
// gives exactly one response on rsp (rsp_valid/rsp_ready), in order.
// One request is in work at a time. An allocate that finds a slot passes
// through the read, execute and wait states, the wait state taking its
// sequence number; a free passes through read and execute, and through wait
// as well when the highest-in-use mark must be found in a lower word of the
// free map; a request that fails up front (no free slot, index out of range)
// goes straight to the done state. A new request is taken the cycle after
// the response is loaded. The free-map RAM is read, modified and written
// back at most once per item, plus a second read of the sequence RAM
// (allocate) or of the free map (mark scan). After reset the block clears
// both RAMs, one sequence entry per cycle, with req_ready low until the
// clear is done. Responses sit in an output register; when the receiver
// stalls, the finished result waits there and the next request still runs
// until its own result needs the register.
`include "assert_macros.svh"

module session_slot_allocator_top #(
	parameter int SLOT_COUNT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  ssa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output ssa_pkg::rsp_t rsp
);

	localparam int NW = (SLOT_COUNT + ssa_pkg::WORD_W - 1) / ssa_pkg::WORD_W;
	localparam int WB = (NW > 1) ? $clog2(NW) : 1;
	localparam int FW_DEPTH = 1 << WB;
	localparam int SW = WB + ssa_pkg::BIT_W;
	localparam int SEQ_DEPTH = 1 << SW;
	localparam int UW = SW + 1;

	// bits of word w that hold real slots
	function automatic logic [ssa_pkg::WORD_W-1:0] valid_mask(input logic [WB-1:0] w);
		logic [ssa_pkg::WORD_W-1:0] m;
		for (int b = 0; b < ssa_pkg::WORD_W; b++) begin
			m[b] = {1'b0, w, ssa_pkg::BIT_W'(b)} < UW'(SLOT_COUNT);
		end
		return m;
	endfunction

	function automatic logic [SW-1:0] sat_limit(input logic [5:0] v);
		return (UW'(v) > UW'(SLOT_COUNT - 1)) ? SW'(SLOT_COUNT - 1) : SW'(v);
	endfunction

	ssa_pkg::state_t state_q, state_d;

	ssa_pkg::req_t   item_q;
	logic [WB-1:0]   word_q;
	logic [4:0]      bit_q;
	logic [WB-1:0]   scan_word_q;
	logic [UW-1:0]   ulp1_q;
	logic [SW-1:0]   srv_q;
	logic [SW-1:0]   tgt_q;
	logic [SW-1:0]   clr_q;
	logic [FW_DEPTH-1:0] free_any_q;
	logic [FW_DEPTH-1:0] busy_any_q;

	logic [ssa_pkg::WORD_W-1:0] fw_mem [FW_DEPTH];
	logic [31:0]                seq_mem [SEQ_DEPTH];
	logic [ssa_pkg::WORD_W-1:0] fw_rd_q;
	logic [31:0]                seq_rd_q;

	logic [1:0]    res_status_q;
	logic [SW-1:0] res_slot_q;
	logic [31:0]   res_seq_q;
	logic [SW-1:0] res_hi_q;
	ssa_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	// decode
	logic          req_fire;
	logic          idx_ok;
	logic [SW-1:0] idx_sw;
	logic          fw_found;
	logic [WB-1:0] fw_word;
	logic [4:0]    fb_idx;
	logic          fb_found;
	logic [SW-1:0] alloc_slot;
	logic          alloc_ok;
	logic [UW-1:0] ulp_alloc;
	logic [SW-1:0] free_slot;
	logic          is_top;
	logic          slot_free;
	logic [ssa_pkg::WORD_W-1:0] wr_word;
	logic [ssa_pkg::WORD_W-1:0] hb_vec;
	logic          hb_found;
	logic [4:0]    hb_idx;
	logic [FW_DEPTH-1:0] bw_vec;
	logic          bw_found;
	logic [WB-1:0] bw_idx;
	logic          clr_last;
	logic          rsp_load;
	logic [UW-1:0] mark_m1;

	// memory controls
	logic          fw_we, fw_re;
	logic [WB-1:0] fw_wa, fw_ra;
	logic [ssa_pkg::WORD_W-1:0] fw_wd;
	logic          seq_we, seq_re;
	logic [SW-1:0] seq_wa, seq_ra;
	logic [31:0]   seq_wd;

	assign req_fire = req_valid && req_ready;
	assign idx_sw = SW'(req.slot_index);
	assign idx_ok = UW'(req.slot_index) < UW'(SLOT_COUNT);
	assign clr_last = clr_q == SW'(SLOT_COUNT - 1);
	assign rsp_load = (state_q == ssa_pkg::S_DONE) && (!rsp_valid_q || rsp_ready);

	ssa_prienc #(.WIDTH(FW_DEPTH), .HIGH(1'b0)) u_free_word (
		.vec(free_any_q), .found(fw_found), .idx(fw_word)
	);

	ssa_prienc #(.WIDTH(ssa_pkg::WORD_W), .HIGH(1'b0)) u_free_bit (
		.vec(fw_rd_q), .found(fb_found), .idx(fb_idx)
	);

	ssa_prienc #(.WIDTH(ssa_pkg::WORD_W), .HIGH(1'b1)) u_busy_bit (
		.vec(hb_vec), .found(hb_found), .idx(hb_idx)
	);

	ssa_prienc #(.WIDTH(FW_DEPTH), .HIGH(1'b1)) u_busy_word (
		.vec(bw_vec), .found(bw_found), .idx(bw_idx)
	);

	always_comb begin
		alloc_slot = {word_q, fb_idx};
		// the word was picked from the free summary, so a free bit is there
		alloc_ok = fb_found && (alloc_slot <= tgt_q);
		ulp_alloc = (UW'(alloc_slot) >= ulp1_q) ? (UW'(alloc_slot) + UW'(1)) : ulp1_q;
		free_slot = {word_q, bit_q};
		is_top = (UW'(free_slot) + UW'(1)) == ulp1_q;
		slot_free = fw_rd_q[bit_q];
		if (item_q.action == ssa_pkg::ACT_ALLOC) begin
			wr_word = fw_rd_q & ~(ssa_pkg::WORD_W'(1) << fb_idx);
		end else begin
			wr_word = fw_rd_q | (ssa_pkg::WORD_W'(1) << bit_q);
		end
		if (state_q == ssa_pkg::S_WAIT) begin
			hb_vec = ~fw_rd_q & valid_mask(scan_word_q);
		end else begin
			hb_vec = ~wr_word & valid_mask(word_q);
		end
		bw_vec = busy_any_q & ((FW_DEPTH'(1) << word_q) - FW_DEPTH'(1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssa_pkg::S_CLEAR: begin
				if (clr_last) state_d = ssa_pkg::S_IDLE;
			end
			ssa_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req.action == ssa_pkg::ACT_ALLOC) begin
						state_d = fw_found ? ssa_pkg::S_READ : ssa_pkg::S_DONE;
					end else begin
						state_d = idx_ok ? ssa_pkg::S_READ : ssa_pkg::S_DONE;
					end
				end
			end
			ssa_pkg::S_READ: state_d = ssa_pkg::S_EXEC;
			ssa_pkg::S_EXEC: begin
				if (item_q.action == ssa_pkg::ACT_ALLOC) begin
					state_d = alloc_ok ? ssa_pkg::S_WAIT : ssa_pkg::S_DONE;
				end else if (!slot_free && is_top && !hb_found && bw_found) begin
					state_d = ssa_pkg::S_WAIT;
				end else begin
					state_d = ssa_pkg::S_DONE;
				end
			end
			ssa_pkg::S_WAIT: state_d = ssa_pkg::S_DONE;
			ssa_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp_ready) state_d = ssa_pkg::S_IDLE;
			end
			default: state_d = ssa_pkg::S_IDLE;
		endcase
	end

	// memory strobes
	always_comb begin
		req_ready = state_q == ssa_pkg::S_IDLE;
		fw_we = 1'b0;
		fw_wa = word_q;
		fw_wd = wr_word;
		fw_re = 1'b0;
		fw_ra = word_q;
		seq_we = 1'b0;
		seq_wa = free_slot;
		seq_wd = seq_rd_q + 32'd1;
		seq_re = 1'b0;
		seq_ra = free_slot;
		case (state_q)
			ssa_pkg::S_CLEAR: begin
				fw_we = {1'b0, clr_q} < UW'(NW);
				fw_wa = clr_q[WB-1:0];
				fw_wd = valid_mask(clr_q[WB-1:0]);
				seq_we = 1'b1;
				seq_wa = clr_q;
				seq_wd = ssa_pkg::SEQ_INIT;
			end
			ssa_pkg::S_READ: begin
				fw_re = 1'b1;
				seq_re = 1'b1;
			end
			ssa_pkg::S_EXEC: begin
				if (item_q.action == ssa_pkg::ACT_ALLOC) begin
					fw_we = alloc_ok;
					seq_re = alloc_ok;
					seq_ra = alloc_slot;
				end else begin
					fw_we = !slot_free;
					seq_we = !slot_free && item_q.was_sent;
					// fetch the next lower word that still holds a busy slot
					fw_re = !slot_free && is_top && !hb_found && bw_found;
					fw_ra = bw_idx;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fw_we) fw_mem[fw_wa] <= fw_wd;
		if (fw_re) fw_rd_q <= fw_mem[fw_ra];
	end

	always_ff @(posedge clk) begin
		if (seq_we) seq_mem[seq_wa] <= seq_wd;
		if (seq_re) seq_rd_q <= seq_mem[seq_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ssa_pkg::S_CLEAR;
			clr_q <= '0;
			ulp1_q <= '0;
			srv_q <= SW'(SLOT_COUNT - 1);
			tgt_q <= SW'(SLOT_COUNT - 1);
			for (int i = 0; i < FW_DEPTH; i++) begin
				free_any_q[i] <= i < NW;
			end
			busy_any_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ssa_pkg::S_CLEAR) clr_q <= clr_q + SW'(1);
			if (state_q == ssa_pkg::S_EXEC && fw_we) begin
				free_any_q[word_q] <= |wr_word;
				busy_any_q[word_q] <= |(~wr_word & valid_mask(word_q));
			end
			if (state_q == ssa_pkg::S_EXEC) begin
				if (item_q.action == ssa_pkg::ACT_ALLOC) begin
					if (alloc_ok) ulp1_q <= ulp_alloc;
				end else if (!slot_free) begin
					if (item_q.was_sent) begin
						srv_q <= sat_limit(item_q.srv_high);
						tgt_q <= sat_limit(item_q.tgt_high);
					end
					if (is_top) begin
						if (hb_found) begin
							ulp1_q <= UW'({word_q, hb_idx}) + UW'(1);
						end else if (!bw_found) begin
							ulp1_q <= '0;
						end
					end
				end
			end
			if (state_q == ssa_pkg::S_WAIT && item_q.action == ssa_pkg::ACT_FREE) begin
				ulp1_q <= UW'({scan_word_q, hb_idx}) + UW'(1);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			item_q <= req;
			word_q <= (req.action == ssa_pkg::ACT_ALLOC) ? fw_word : idx_sw[SW-1:ssa_pkg::BIT_W];
			bit_q <= idx_sw[ssa_pkg::BIT_W-1:0];
			res_status_q <= (req.action == ssa_pkg::ACT_ALLOC) ? ssa_pkg::STATUS_NO_SLOT
				: ssa_pkg::STATUS_NOT_BUSY;
			res_slot_q <= '0;
			res_seq_q <= '0;
			res_hi_q <= '0;
		end
		if (state_q == ssa_pkg::S_EXEC) begin
			scan_word_q <= bw_idx;
			if (item_q.action == ssa_pkg::ACT_ALLOC) begin
				res_status_q <= alloc_ok ? ssa_pkg::STATUS_OK : ssa_pkg::STATUS_NO_SLOT;
				res_slot_q <= alloc_ok ? alloc_slot : '0;
				res_hi_q <= alloc_ok ? SW'(ulp_alloc - UW'(1)) : '0;
			end else begin
				res_status_q <= slot_free ? ssa_pkg::STATUS_NOT_BUSY : ssa_pkg::STATUS_OK;
			end
		end
		if (state_q == ssa_pkg::S_WAIT && item_q.action == ssa_pkg::ACT_ALLOC) begin
			res_seq_q <= seq_rd_q;
		end
		if (rsp_load) begin
			rsp_q.status <= res_status_q;
			rsp_q.granted_slot <= res_slot_q[5:0];
			rsp_q.sequence_number <= res_seq_q;
			rsp_q.highest_in_use <= res_hi_q[5:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;
	assign mark_m1 = ulp1_q - UW'(1);

	`SSA_ASSERT_ALWAYS(a_mark_in_range, ulp1_q <= UW'(SLOT_COUNT))
	`SSA_ASSERT(a_mark_is_busy, state_q == ssa_pkg::S_IDLE && ulp1_q != '0 |-> busy_any_q[mark_m1[SW-1:ssa_pkg::BIT_W]])
	`SSA_ASSERT(a_grant_below_mark, state_q == ssa_pkg::S_DONE && item_q.action == ssa_pkg::ACT_ALLOC && res_status_q == ssa_pkg::STATUS_OK |-> res_hi_q >= res_slot_q)
	`SSA_ASSERT(a_rsp_from_done, $rose(rsp_valid) |-> $past(state_q) == ssa_pkg::S_DONE)

endmodule

### rtl/ssa_prienc.sv
// Priority encoder: position of the lowest or highest set bit of a vector.
// No dependencies.
module ssa_prienc #(
	parameter int WIDTH = 32,
	parameter bit HIGH = 1'b0,
	localparam int IW = (WIDTH > 1) ? $clog2(WIDTH) : 1
) (
	input  logic [WIDTH-1:0] vec,
	output logic             found,
	output logic [IW-1:0]    idx
);

	logic [WIDTH-1:0] ord;
	logic [WIDTH-1:0] iso;

	always_comb begin
		for (int i = 0; i < WIDTH; i++) begin
			ord[i] = HIGH ? vec[WIDTH-1-i] : vec[i];
		end
		// isolate the first set bit, then map the one-hot to its position
		iso = ord & (~ord + WIDTH'(1));
		idx = '0;
		for (int i = 0; i < WIDTH; i++) begin
			if (iso[i]) begin
				idx = idx | IW'(HIGH ? (WIDTH - 1 - i) : i);
			end
		end
	end

	assign found = |vec;

endmodule
